// ===== rtl/sastl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sastl_pkg
// Shared sizes, action codes and types of the set-associative tag store.
// ----------------------------------------------------------------------------
package sastl_pkg;

    localparam int NUM_SETS   = 64;
    localparam int NUM_WAYS   = 16;
    localparam int TAG_BITS   = 20;
    localparam int STAMP_BITS = 32;

    localparam int SET_W = $clog2(NUM_SETS);
    localparam int WAY_W = $clog2(NUM_WAYS);

    // port widths of the item fields
    localparam int ACTION_W    = 2;
    localparam int SET_INDEX_W = 6;
    localparam int TAG_IN_W    = 20;
    localparam int WAY_SEL_W   = 4;
    localparam int WAY_OUT_W   = 4;

    localparam int TAG_ROW_W   = NUM_WAYS * TAG_BITS;
    localparam int STAMP_ROW_W = NUM_WAYS * STAMP_BITS;

    localparam logic [STAMP_BITS-1:0] STAMP_MAX = {STAMP_BITS{1'b1}};

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_TOUCH  = 2'd2,
        ACT_INVAL  = 2'd3
    } t_action;

    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] way;
        logic             wr;
    } t_way_res;

endpackage

// ===== rtl/set_assoc_tag_store_lru.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_tag_store_lru
// Set-associative tag store with timestamp LRU; each set is one RAM row.
// ----------------------------------------------------------------------------
// result: registered into the output register as execute ends, once that
//   register is free; a held output keeps the item in execute
// items: a new item is taken only in idle, so it waits until the last one has
//   left execute, where its set row is read from and written back to the RAMs
// reset: stamp counter and per-set valid bits clear on a synchronous reset; a set not
//   yet written reads as all zero, so no clearing pass is needed
module set_assoc_tag_store_lru (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [sastl_pkg::ACTION_W-1:0]       i_action,
    input  logic [sastl_pkg::SET_INDEX_W-1:0]    i_set_index,
    input  logic [sastl_pkg::TAG_IN_W-1:0]       i_tag,
    input  logic [sastl_pkg::WAY_SEL_W-1:0]      i_way_sel,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_hit,
    output logic [sastl_pkg::WAY_OUT_W-1:0]      o_way_out
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;

    sastl_pkg::t_action                   r_action;
    logic [sastl_pkg::SET_W-1:0]          r_set;
    logic [sastl_pkg::TAG_BITS-1:0]       r_tag;
    logic [sastl_pkg::WAY_SEL_W-1:0]      r_way_sel;

    logic [sastl_pkg::STAMP_BITS-1:0]     r_cnt, n_cnt;
    logic [sastl_pkg::NUM_SETS-1:0]       r_row_vld;

    logic                                 r_o_valid;
    logic                                 r_o_hit;
    logic [sastl_pkg::WAY_W-1:0]          r_o_way;

    logic                                 accept;
    logic                                 go;
    logic                                 ram_we;
    logic [sastl_pkg::SET_W-1:0]          rd_set;
    logic [sastl_pkg::TAG_ROW_W-1:0]      tag_rdata, tag_row, tag_wrow;
    logic [sastl_pkg::STAMP_ROW_W-1:0]    stamp_rdata, stamp_row, stamp_wrow;
    logic [sastl_pkg::STAMP_BITS-1:0]     new_stamp;
    sastl_pkg::t_way_res                  res;

    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;
    assign go      = (r_state == ST_EXEC) && (!r_o_valid || i_ready);
    assign ram_we  = go && res.wr;
    assign rd_set  = sastl_pkg::SET_W'(i_set_index % sastl_pkg::NUM_SETS);

    // a set never written reads as zero tags and zero (invalid) stamps
    assign tag_row   = r_row_vld[r_set] ? tag_rdata : '0;
    assign stamp_row = r_row_vld[r_set] ? stamp_rdata : '0;

    assign new_stamp = (r_cnt == sastl_pkg::STAMP_MAX) ? r_cnt : r_cnt + 1'b1;

    sastl_ram #(
        .WIDTH (sastl_pkg::TAG_ROW_W),
        .DEPTH (sastl_pkg::NUM_SETS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_set),
        .i_wdata (tag_wrow),
        .i_re    (accept),
        .i_raddr (rd_set),
        .o_rdata (tag_rdata)
    );

    sastl_ram #(
        .WIDTH (sastl_pkg::STAMP_ROW_W),
        .DEPTH (sastl_pkg::NUM_SETS)
    ) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_set),
        .i_wdata (stamp_wrow),
        .i_re    (accept),
        .i_raddr (rd_set),
        .o_rdata (stamp_rdata)
    );

    sastl_way_ctl u_way_ctl (
        .i_action    (r_action),
        .i_tag       (r_tag),
        .i_way_sel   (r_way_sel),
        .i_new_stamp (new_stamp),
        .i_tag_row   (tag_row),
        .i_stamp_row (stamp_row),
        .o_tag_row   (tag_wrow),
        .o_stamp_row (stamp_wrow),
        .o_res       (res)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // hold the read row until the output register can take the item
                if (go) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign n_cnt = ram_we ? new_stamp : r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_row_vld <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (ram_we) begin
                r_row_vld[r_set] <= 1'b1;
            end
            if (go) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action  <= sastl_pkg::t_action'(i_action);
            r_set     <= rd_set;
            r_tag     <= sastl_pkg::TAG_BITS'(i_tag);
            r_way_sel <= i_way_sel;
        end
        if (go) begin
            r_o_hit <= res.hit;
            r_o_way <= res.way;
        end
    end

    assign o_valid   = r_o_valid;
    assign o_hit     = r_o_hit;
    assign o_way_out = sastl_pkg::WAY_OUT_W'(r_o_way);

`ifndef SYNTHESIS
    a_we_in_exec : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == ST_EXEC))
        else $error("set row written outside the execute state");

    a_cnt_monotonic : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |=> (r_cnt >= $past(r_cnt)))
        else $error("stamp counter went backwards");

    a_result_after_go : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go |=> o_valid)
        else $error("finished item not presented at the output");

    a_hit_only_lookup : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && (r_action != sastl_pkg::ACT_LOOKUP)) |=> !o_hit)
        else $error("hit flagged on a non-lookup item");
`endif

endmodule

// ===== rtl/sastl_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sastl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sastl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sastl_way_ctl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sastl_way_ctl
// Per-set way logic: tag match, LRU victim choice and the updated set row.
// ----------------------------------------------------------------------------
module sastl_way_ctl (
    input  sastl_pkg::t_action                       i_action,
    input  logic [sastl_pkg::TAG_BITS-1:0]           i_tag,
    input  logic [sastl_pkg::WAY_SEL_W-1:0]          i_way_sel,
    input  logic [sastl_pkg::STAMP_BITS-1:0]         i_new_stamp,
    input  logic [sastl_pkg::TAG_ROW_W-1:0]          i_tag_row,
    input  logic [sastl_pkg::STAMP_ROW_W-1:0]        i_stamp_row,
    output logic [sastl_pkg::TAG_ROW_W-1:0]          o_tag_row,
    output logic [sastl_pkg::STAMP_ROW_W-1:0]        o_stamp_row,
    output sastl_pkg::t_way_res                      o_res
);

    logic [sastl_pkg::TAG_BITS-1:0]   tags   [sastl_pkg::NUM_WAYS];
    logic [sastl_pkg::STAMP_BITS-1:0] stamps [sastl_pkg::NUM_WAYS];
    logic [sastl_pkg::NUM_WAYS-1:0]   match;
    logic [sastl_pkg::NUM_WAYS-1:0]   victim;
    logic [sastl_pkg::WAY_W-1:0]      hit_way;
    logic [sastl_pkg::WAY_W-1:0]      victim_way;

    always_comb begin
        for (int w = 0; w < sastl_pkg::NUM_WAYS; w++) begin
            tags[w]   = i_tag_row[w*sastl_pkg::TAG_BITS +: sastl_pkg::TAG_BITS];
            stamps[w] = i_stamp_row[w*sastl_pkg::STAMP_BITS +: sastl_pkg::STAMP_BITS];
            match[w]  = (tags[w] == i_tag) && (stamps[w] != '0);
        end
    end

    // victim is the highest way holding the minimum stamp:
    // not above any lower way, strictly below every higher way
    always_comb begin
        for (int w = 0; w < sastl_pkg::NUM_WAYS; w++) begin
            victim[w] = 1'b1;
            for (int v = 0; v < sastl_pkg::NUM_WAYS; v++) begin
                if (v < w) begin
                    victim[w] = victim[w] & (stamps[w] <= stamps[v]);
                end else if (v > w) begin
                    victim[w] = victim[w] & (stamps[w] < stamps[v]);
                end
            end
        end
    end

    always_comb begin
        victim_way = '0;
        for (int w = 0; w < sastl_pkg::NUM_WAYS; w++) begin
            if (victim[w]) begin
                victim_way = victim_way | sastl_pkg::WAY_W'(w);
            end
        end
    end

    // lowest matching way wins
    always_comb begin
        hit_way = '0;
        for (int w = sastl_pkg::NUM_WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit_way = sastl_pkg::WAY_W'(w);
            end
        end
    end

    always_comb begin
        o_tag_row   = i_tag_row;
        o_stamp_row = i_stamp_row;
        o_res.hit   = 1'b0;
        o_res.way   = '0;
        o_res.wr    = 1'b1;
        case (i_action)
            sastl_pkg::ACT_LOOKUP: begin
                o_res.wr  = 1'b0;
                o_res.hit = |match;
                o_res.way = hit_way;
            end
            sastl_pkg::ACT_INSERT: begin
                o_res.way = victim_way;
                for (int w = 0; w < sastl_pkg::NUM_WAYS; w++) begin
                    if (victim[w]) begin
                        o_tag_row[w*sastl_pkg::TAG_BITS +: sastl_pkg::TAG_BITS] = i_tag;
                        o_stamp_row[w*sastl_pkg::STAMP_BITS +: sastl_pkg::STAMP_BITS] =
                            i_new_stamp;
                    end
                end
            end
            sastl_pkg::ACT_TOUCH: begin
                // a way_sel beyond the last way matches nothing
                for (int w = 0; w < sastl_pkg::NUM_WAYS; w++) begin
                    if (i_way_sel == sastl_pkg::WAY_SEL_W'(w)) begin
                        o_stamp_row[w*sastl_pkg::STAMP_BITS +: sastl_pkg::STAMP_BITS] =
                            i_new_stamp;
                    end
                end
            end
            sastl_pkg::ACT_INVAL: begin
                for (int w = 0; w < sastl_pkg::NUM_WAYS; w++) begin
                    if (i_way_sel == sastl_pkg::WAY_SEL_W'(w)) begin
                        o_stamp_row[w*sastl_pkg::STAMP_BITS +: sastl_pkg::STAMP_BITS] = '0;
                    end
                end
            end
            default: begin
                o_res.wr = 1'b0;
            end
        endcase
    end

endmodule
